// ===== sv/apd_pkg.sv =====
// Shared types, constants and arithmetic helpers for the phase-control dimmer.
// Used by every module of the dimmer; depends on nothing.
`timescale 1ns / 1ps

package apd_pkg;

  // Width of the measured half-period taken from each zero-crossing transfer
  localparam int unsigned PeriodWidth = 16;
  // Width of the period times level product
  localparam int unsigned ProdWidth   = PeriodWidth + 8;
  // Number of shifted terms in the divide-by-255 estimate
  localparam int unsigned DivTerms    = (ProdWidth - 1) / 8;

  localparam logic [7:0] LevelFull  = 8'd255;
  localparam logic [9:0] PulseReset = 10'd50;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CfgDimmerMode = 1'b0,
    CfgGatePulse  = 1'b1
  } cfg_reg_e;

  // Request kinds carried by an input transfer
  typedef enum logic [0:0] {
    ReqTick     = 1'b0,
    ReqCrossing = 1'b1
  } req_type_e;

  // Dimming modes
  typedef enum logic [0:0] {
    ModeTrailing = 1'b0,
    ModeLeading  = 1'b1
  } dim_mode_e;

  typedef struct packed {
    logic        req_type;
    logic [7:0]  level;
    logic [15:0] half_period_us;
  } in_item_t;

  typedef struct packed {
    logic gate;
    logic timing_pending;
  } out_item_t;

  // Item held in the input stage, with the scaled period already formed
  typedef struct packed {
    logic                 req_type;
    logic [7:0]           level;
    logic [ProdWidth-1:0] product;
  } stage_item_t;

  // Low PeriodWidth bits of the 16-bit period field, zero-extended if wider
  function automatic logic [PeriodWidth-1:0] period_of(input logic [15:0] field);
    logic [PeriodWidth+15:0] ext;
    ext = {{PeriodWidth{1'b0}}, field};
    return ext[PeriodWidth-1:0];
  endfunction

  // Exact x / 255: shift-add estimate from below, then a small remainder fix
  function automatic logic [PeriodWidth-1:0] div255(input logic [ProdWidth-1:0] x);
    logic [ProdWidth-1:0] est;
    logic [ProdWidth-1:0] rem_full;
    logic [10:0]          rem;
    logic [11:0]          fix_sum;
    logic [ProdWidth-1:0] quo;
    est = '0;
    for (int unsigned i = 1; i <= DivTerms; i++) begin
      est = est + (x >> (8 * i));
    end
    // remainder x - 255*est stays below 2048
    rem_full = x - (est << 8) + est;
    rem      = rem_full[10:0];
    fix_sum  = {1'b0, rem} + 12'd1 + {9'd0, rem[10:8]};
    quo      = est + {{(ProdWidth-4){1'b0}}, fix_sum[11:8]};
    return quo[PeriodWidth-1:0];
  endfunction

endpackage

// ===== sv/ac_phase_dimmer_top.sv =====
// Top level of the phase-control dimmer gate driver: configuration registers
// and the two pipeline stages. Depends on apd_pkg, apd_in_stage, apd_timer.
`timescale 1ns / 1ps

// Every input transfer (a microsecond tick or a zero crossing) yields exactly
// one result transfer with the gate level and a timing-pending flag. The block
// takes one item per clock cycle while results are accepted. The input stage
// registers each transfer with the period times level product; the timer stage
// divides it by 255, registers the result and updates the single phase/pulse
// timer, the one state update that limits throughput to one item a cycle.
// Configuration writes (mode, gate pulse width) take effect on the next
// cycle and must be made while no transfer is in flight.
module ac_phase_dimmer_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [0:0]          cfg_idx_i,
  input  logic [9:0]          cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  apd_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output apd_pkg::out_item_t  out_item_o
);

  logic                 mode_q;
  logic [9:0]           pulse_ticks_q;
  logic                 stage_valid;
  logic                 stage_ready;
  apd_pkg::stage_item_t stage_item;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= apd_pkg::ModeTrailing;
      pulse_ticks_q <= apd_pkg::PulseReset;
    end else if (cfg_we_i) begin
      case (apd_pkg::cfg_reg_e'(cfg_idx_i))
        apd_pkg::CfgDimmerMode: mode_q        <= cfg_wdata_i[0];
        apd_pkg::CfgGatePulse:  pulse_ticks_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  apd_in_stage u_in_stage (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .mode_i        (mode_q),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_item_i     (in_item_i),
    .stage_valid_o (stage_valid),
    .stage_ready_i (stage_ready),
    .stage_item_o  (stage_item)
  );

  apd_timer u_timer (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .mode_i        (mode_q),
    .pulse_ticks_i (pulse_ticks_q),
    .stage_valid_i (stage_valid),
    .stage_ready_o (stage_ready),
    .stage_item_i  (stage_item),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_item_o    (out_item_o)
  );

endmodule

// ===== sv/apd_in_stage.sv =====
// Input stage of the dimmer: registers an accepted transfer together with
// the period times level product. Depends on apd_pkg.
`timescale 1ns / 1ps

module apd_in_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                mode_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  apd_pkg::in_item_t   in_item_i,
  output logic                stage_valid_o,
  input  logic                stage_ready_i,
  output apd_pkg::stage_item_t stage_item_o
);

  logic                        valid_q, valid_d;
  apd_pkg::stage_item_t        item_q;
  logic                        accept;
  logic [7:0]                  scale;
  logic [apd_pkg::PeriodWidth-1:0] period;

  // Stage frees up when empty or when its item moves on
  assign in_ready_o = !valid_q || stage_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // Trailing mode scales by level, leading mode by the remaining phase
  assign scale  = (mode_i == apd_pkg::ModeLeading) ? (apd_pkg::LevelFull - in_item_i.level)
                                                   : in_item_i.level;
  assign period = apd_pkg::period_of(in_item_i.half_period_us);

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (stage_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload register, no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.req_type <= in_item_i.req_type;
      item_q.level    <= in_item_i.level;
      item_q.product  <= {8'd0, period} * {{(apd_pkg::PeriodWidth){1'b0}}, scale};
    end
  end

  assign stage_valid_o = valid_q;
  assign stage_item_o  = item_q;

endmodule

// ===== sv/apd_timer.sv =====
// Phase timer and gate state of the dimmer, plus the result register.
// Consumes items from apd_in_stage. Depends on apd_pkg.
`timescale 1ns / 1ps

module apd_timer (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 mode_i,
  input  logic [9:0]           pulse_ticks_i,
  input  logic                 stage_valid_i,
  output logic                 stage_ready_o,
  input  apd_pkg::stage_item_t stage_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output apd_pkg::out_item_t   out_item_o
);

  logic [apd_pkg::PeriodWidth-1:0] phase_count_q, phase_count_d;
  logic                            phase_armed_q, phase_armed_d;
  logic [9:0]                      pulse_count_q, pulse_count_d;
  logic                            pulse_armed_q, pulse_armed_d;
  logic                            gate_level_q, gate_level_d;
  logic                            out_valid_q, out_valid_d;
  apd_pkg::out_item_t              out_item_q;
  logic                            fire;
  logic [apd_pkg::PeriodWidth-1:0] delay;

  assign stage_ready_o = !out_valid_q || out_ready_i;
  assign fire          = stage_valid_i && stage_ready_o;
  assign delay         = apd_pkg::div255(stage_item_i.product);

  // Next timer and gate state for the item in the input stage
  always_comb begin
    phase_count_d = phase_count_q;
    phase_armed_d = phase_armed_q;
    pulse_count_d = pulse_count_q;
    pulse_armed_d = pulse_armed_q;
    gate_level_d  = gate_level_q;
    if (stage_item_i.req_type == apd_pkg::ReqTick) begin
      // pulse counter first
      if (pulse_armed_q) begin
        if (pulse_count_q <= 10'd1) begin
          pulse_armed_d = 1'b0;
          pulse_count_d = '0;
          gate_level_d  = 1'b0;
        end else begin
          pulse_count_d = pulse_count_q - 10'd1;
        end
      end
      // then the phase delay; expiry acts on the current mode
      if (phase_armed_q) begin
        if (phase_count_q <= {{(apd_pkg::PeriodWidth-1){1'b0}}, 1'b1}) begin
          phase_armed_d = 1'b0;
          phase_count_d = '0;
          if (mode_i == apd_pkg::ModeTrailing) begin
            gate_level_d = 1'b0;
          end else begin
            gate_level_d  = 1'b1;
            pulse_count_d = pulse_ticks_i;
            pulse_armed_d = 1'b1;
          end
        end else begin
          phase_count_d = phase_count_q - {{(apd_pkg::PeriodWidth-1){1'b0}}, 1'b1};
        end
      end
    end else begin
      // zero crossing restarts all timing
      phase_armed_d = 1'b0;
      phase_count_d = '0;
      pulse_armed_d = 1'b0;
      pulse_count_d = '0;
      if (mode_i == apd_pkg::ModeTrailing) begin
        if (stage_item_i.level == 8'd0) begin
          gate_level_d = 1'b0;
        end else begin
          gate_level_d = 1'b1;
          if (stage_item_i.level != apd_pkg::LevelFull) begin
            phase_count_d = delay;
            phase_armed_d = 1'b1;
          end
        end
      end else begin
        gate_level_d  = 1'b0;
        phase_count_d = delay;
        phase_armed_d = 1'b1;
      end
    end
  end

  // Result register handshake
  always_comb begin
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_count_q <= '0;
      phase_armed_q <= 1'b0;
      pulse_count_q <= '0;
      pulse_armed_q <= 1'b0;
      gate_level_q  <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (fire) begin
        phase_count_q <= phase_count_d;
        phase_armed_q <= phase_armed_d;
        pulse_count_q <= pulse_count_d;
        pulse_armed_q <= pulse_armed_d;
        gate_level_q  <= gate_level_d;
      end
    end
  end

  // Result payload, no reset
  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_item_q.gate           <= gate_level_d;
      out_item_q.timing_pending <= phase_armed_d || pulse_armed_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // Only one of the two timers runs at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pulse_armed_q && phase_armed_q))
    else $error("phase delay and gate pulse armed together");

  // A running gate pulse always has the gate driven high
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pulse_armed_q |-> gate_level_q)
    else $error("gate pulse armed with gate low");

  // A zero crossing cancels any gate pulse
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && stage_item_i.req_type == apd_pkg::ReqCrossing) |=> !pulse_armed_q)
    else $error("gate pulse survived a zero crossing");

  // The result transfer reports the gate state just stored
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> (out_item_q.gate == gate_level_q &&
              out_item_q.timing_pending == (phase_armed_q || pulse_armed_q)))
    else $error("result does not match timer state");

endmodule

// ===== tb/sv/apd_gate_checker.sv =====
// Checker for the phase-control dimmer: tracks the configuration registers,
// predicts gate and timing-pending for every input transfer and compares them
// with the result transfers. Depends on apd_pkg.
`timescale 1ns / 1ps

module apd_gate_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [0:0]         cfg_idx_i,
  input  logic [9:0]         cfg_wdata_i,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  apd_pkg::in_item_t  in_item_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  apd_pkg::out_item_t out_item_i,
  output int                 fail_count_o,
  output int                 in_flight_o
);

  // Shadow of the configuration registers
  apd_pkg::dim_mode_e mode_q;
  logic [9:0]         pulse_width_q;

  // Shadow of the single phase/pulse timer
  logic [15:0] phase_left;
  logic        phase_on;
  logic [9:0]  pulse_left;
  logic        pulse_on;
  logic        gate_on;

  // Predicted gate levels, oldest first
  apd_pkg::out_item_t gate_forecast_q[$];

  assign in_flight_o = gate_forecast_q.size();

  // Applies one input transfer to the shadow timer and returns the outputs
  task automatic predict_gate_drive(input apd_pkg::in_item_t item,
                                    output apd_pkg::out_item_t res);
    logic [31:0] prod;
    logic [15:0] delay;
    if (apd_pkg::req_type_e'(item.req_type) == apd_pkg::ReqTick) begin
      // pulse counter first, then the phase delay
      if (pulse_on) begin
        if (pulse_left <= 10'd1) begin
          pulse_on   = 1'b0;
          pulse_left = '0;
          gate_on    = 1'b0;
        end else begin
          pulse_left = pulse_left - 10'd1;
        end
      end
      if (phase_on) begin
        if (phase_left <= 16'd1) begin
          phase_on   = 1'b0;
          phase_left = '0;
          if (mode_q == apd_pkg::ModeTrailing) begin
            gate_on = 1'b0;
          end else begin
            gate_on    = 1'b1;
            pulse_left = pulse_width_q;
            pulse_on   = 1'b1;
          end
        end else begin
          phase_left = phase_left - 16'd1;
        end
      end
    end else begin
      // zero crossing restarts all timing
      phase_on   = 1'b0;
      phase_left = '0;
      pulse_on   = 1'b0;
      pulse_left = '0;
      if (mode_q == apd_pkg::ModeTrailing) begin
        gate_on = (item.level != 8'd0);
        if (item.level != 8'd0 && item.level != apd_pkg::LevelFull) begin
          prod       = 32'(item.half_period_us) * 32'(item.level);
          delay      = 16'(prod / 32'd255);
          phase_left = delay;
          phase_on   = 1'b1;
        end
      end else begin
        gate_on    = 1'b0;
        prod       = 32'(item.half_period_us) * 32'(apd_pkg::LevelFull - item.level);
        delay      = 16'(prod / 32'd255);
        phase_left = delay;
        phase_on   = 1'b1;
      end
    end
    res.gate           = gate_on;
    res.timing_pending = phase_on | pulse_on;
  endtask

  always_ff @(posedge clk_i or negedge rst_ni) begin
    apd_pkg::out_item_t predicted;
    apd_pkg::out_item_t oldest;
    int                 mism;
    if (!rst_ni) begin
      mode_q        <= apd_pkg::ModeTrailing;
      pulse_width_q <= apd_pkg::PulseReset;
      phase_left     = '0;
      phase_on       = 1'b0;
      pulse_left     = '0;
      pulse_on       = 1'b0;
      gate_on        = 1'b0;
      fail_count_o  <= 0;
      gate_forecast_q.delete();
    end else begin
      mism = 0;
      // register writes land at this edge
      if (cfg_we_i) begin
        if (apd_pkg::cfg_reg_e'(cfg_idx_i) == apd_pkg::CfgDimmerMode) begin
          mode_q <= apd_pkg::dim_mode_e'(cfg_wdata_i[0]);
        end else if (apd_pkg::cfg_reg_e'(cfg_idx_i) == apd_pkg::CfgGatePulse) begin
          pulse_width_q <= cfg_wdata_i;
        end
      end
      // input transfer: predict before any result is popped
      if (in_valid_i && in_ready_i) begin
        predict_gate_drive(in_item_i, predicted);
        gate_forecast_q.push_back(predicted);
      end
      // result transfer: compare with the oldest prediction
      if (out_valid_i && out_ready_i) begin
        if (gate_forecast_q.size() == 0) begin
          $error("unexpected result transfer: gate=%0b timing_pending=%0b",
                 out_item_i.gate, out_item_i.timing_pending);
          mism++;
        end else begin
          oldest = gate_forecast_q.pop_front();
          if (out_item_i.gate !== oldest.gate) begin
            $error("gate mismatch: expected %0b, actual %0b",
                   oldest.gate, out_item_i.gate);
            mism++;
          end
          if (out_item_i.timing_pending !== oldest.timing_pending) begin
            $error("timing_pending mismatch: expected %0b, actual %0b",
                   oldest.timing_pending, out_item_i.timing_pending);
            mism++;
          end
        end
      end
      fail_count_o <= fail_count_o + mism;
    end
  end

endmodule

// ===== tb/sv/testbench.sv =====
// Top of the dimmer testbench: clock, reset, stimulus and verdict.
// Depends on apd_pkg, ac_phase_dimmer_top and apd_gate_checker.
`timescale 1ns / 1ps

module testbench;

  localparam int ItemTarget = 1850;
  localparam int CycleLimit = 400000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [0:0]         cfg_idx = '0;
  logic [9:0]         cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  apd_pkg::in_item_t  in_item = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  apd_pkg::out_item_t out_item;

  int fail_count;
  int in_flight;
  int sent = 0;
  int cycle_cnt = 0;
  bit steady = 1'b0;

  // Stimulus-side copy of the settings, only to size tick bursts
  apd_pkg::dim_mode_e cur_mode = apd_pkg::ModeTrailing;
  logic [9:0]         cur_width = apd_pkg::PulseReset;

  always #6 clk = ~clk;

  ac_phase_dimmer_top i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item)
  );

  apd_gate_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_item_i    (in_item),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_item_i   (out_item),
    .fail_count_o (fail_count),
    .in_flight_o  (in_flight)
  );

  // Result side backpressure
  always @(negedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= 25);
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // One input transfer, with random gaps in front of it
  task automatic send_item(input apd_pkg::req_type_e kind, input logic [7:0] lvl,
                           input logic [15:0] per);
    while (!steady && $urandom_range(0, 99) < 25) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= '{req_type: kind, level: lvl, half_period_us: per};
    do @(posedge clk); while (!in_ready);
    sent++;
    @(negedge clk);
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_item(apd_pkg::ReqTick, 8'($urandom), 16'($urandom));
  endtask

  // Wait for every predicted result, then let the pipeline empty
  task automatic settle();
    in_valid <= 1'b0;
    while (in_flight != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input apd_pkg::cfg_reg_e idx, input logic [9:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (idx == apd_pkg::CfgDimmerMode) cur_mode = apd_pkg::dim_mode_e'(val[0]);
    else cur_width = val;
  endtask

  // Expected length of the timing that a crossing starts, in ticks
  function automatic int timing_span(input logic [7:0] lvl, input logic [15:0] per);
    int span;
    if (cur_mode == apd_pkg::ModeTrailing) begin
      span = (int'(per) * int'(lvl)) / 255;
    end else begin
      span = (int'(per) * (255 - int'(lvl))) / 255 + int'(cur_width);
    end
    return span;
  endfunction

  function automatic logic [15:0] pick_period();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return 16'($urandom_range(0, 65535));
    if (r == 1) return 16'd0;
    if (r == 2) return 16'hFFFF;
    return 16'($urandom_range(1, 300));
  endfunction

  function automatic logic [7:0] pick_level();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return 8'd0;
    if (r == 1) return apd_pkg::LevelFull;
    return 8'($urandom_range(0, 255));
  endfunction

  initial begin
    int phase_no;
    int kind;
    int span;
    int ticks;
    logic [7:0]  lvl;
    logic [15:0] per;
    logic [9:0]  width;

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: trailing mode at reset settings
    send_item(apd_pkg::ReqCrossing, 8'd0, 16'd100);      // level zero: gate off
    send_ticks(1);
    send_item(apd_pkg::ReqCrossing, apd_pkg::LevelFull, 16'hFFFF); // full: gate on
    send_ticks(1);
    send_item(apd_pkg::ReqCrossing, 8'd1, 16'd0);        // zero delay fires on next tick
    send_ticks(2);
    send_item(apd_pkg::ReqCrossing, 8'd128, 16'd6);      // delay of three ticks
    send_ticks(4);
    settle();

    // Directed: leading mode, short pulse
    write_reg(apd_pkg::CfgDimmerMode, 10'(apd_pkg::ModeLeading));
    write_reg(apd_pkg::CfgGatePulse, 10'd2);
    send_item(apd_pkg::ReqCrossing, apd_pkg::LevelFull, 16'd40); // zero delay, 2-tick pulse
    send_ticks(3);
    send_item(apd_pkg::ReqCrossing, 8'd0, 16'hFFFF);     // longest delay
    send_item(apd_pkg::ReqCrossing, 8'd170, 16'd3);      // crossing restarts the timer
    send_ticks(3);
    settle();

    // Mode change while a trailing delay is pending: expiry starts a pulse
    write_reg(apd_pkg::CfgDimmerMode, 10'(apd_pkg::ModeTrailing));
    send_item(apd_pkg::ReqCrossing, 8'd128, 16'd20);
    send_ticks(2);
    settle();
    write_reg(apd_pkg::CfgDimmerMode, 10'(apd_pkg::ModeLeading));
    write_reg(apd_pkg::CfgGatePulse, 10'd3);
    send_ticks(12);
    settle();

    // Random phases, each with its own settings
    phase_no = 0;
    while (sent < ItemTarget) begin
      settle();
      steady = (phase_no == 2);
      if (phase_no == 0 || $urandom_range(0, 3) != 0) begin
        write_reg(apd_pkg::CfgDimmerMode, 10'($urandom_range(0, 1)));
      end
      kind = $urandom_range(0, 15);
      if (kind == 0) width = 10'd0;          // out of range, acts as one tick
      else if (kind == 1) width = 10'd1023;
      else if (kind < 4) width = 10'd1;
      else width = 10'($urandom_range(2, 40));
      if (phase_no == 0 || $urandom_range(0, 3) != 0) write_reg(apd_pkg::CfgGatePulse, width);

      repeat ($urandom_range(3, 8)) begin
        if (sent < ItemTarget) begin
          kind = $urandom_range(0, 9);
          if (kind == 0) begin
            // stray ticks
            send_ticks($urandom_range(1, 10));
          end else if (kind == 1) begin
            // crossings back to back
            repeat ($urandom_range(2, 4)) begin
              send_item(apd_pkg::ReqCrossing, 8'($urandom), 16'($urandom));
            end
          end else if (kind == 2) begin
            // hold off until the block has delivered everything
            in_valid <= 1'b0;
            while (in_flight != 0) @(negedge clk);
            @(negedge clk);
          end else begin
            // crossing followed by a run of ticks
            lvl = pick_level();
            per = pick_period();
            send_item(apd_pkg::ReqCrossing, lvl, per);
            span = timing_span(lvl, per);
            if ($urandom_range(0, 2) != 0) ticks = span + $urandom_range(0, 4);
            else ticks = $urandom_range(0, span + 2);
            if (ticks > 1200) ticks = $urandom_range(20, 80);
            send_ticks(ticks);
          end
        end
      end
      phase_no++;
    end
    steady = 1'b0;

    settle();
    repeat (8) @(negedge clk);
    if (fail_count == 0 && in_flight == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/apd_pkg.sv
sv/apd_in_stage.sv
sv/apd_timer.sv
sv/ac_phase_dimmer_top.sv
tb/sv/apd_gate_checker.sv
tb/sv/testbench.sv
